FILE: sv/dcsp_pkg.sv
// Shared widths, reset values, register indexes and control structs
// of the distributed-clock sync PI unit. No dependencies.
package dcsp_pkg;

    localparam int INTEG_W  = 48;                 // width of the phase integral
    localparam int TIME_W   = 63;                 // reference time width
    localparam int CYC_W    = 30;                 // cycle time / shift width
    localparam int GAIN_W   = 32;                 // Q0.32 gains
    localparam int CFG_W    = 32;                 // widest register
    localparam int OUT_W    = 34;                 // correction width
    localparam int DIFF_W   = TIME_W + 1;         // signed time minus shift
    localparam int MAG_W    = TIME_W;             // magnitude of the difference
    localparam int DELTA_W  = CYC_W + 1;          // signed phase error
    localparam int MUL_W    = 32;                 // shared multiplier operand
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = INTEG_W + 34;       // exact sum of both terms
    localparam int Q_W      = ACC_W - GAIN_W;     // sum after dropping fraction
    localparam int DIV_CNT_W = $clog2(MAG_W);

    localparam logic [CYC_W-1:0]  CYCLE_TIME_RST = CYC_W'(50000000);
    localparam logic [CYC_W-1:0]  SYNC_SHIFT_RST = CYC_W'(500000);
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(42949673);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(85899);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic [Q_W-1:0]   OUT_POS_MAX = Q_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic [Q_W-1:0]   OUT_NEG_MAG = Q_W'({1'b1, {(OUT_W-1){1'b0}}});
    localparam logic [OUT_W-1:0] OUT_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN     = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_CYCLE_TIME = 2'd0,
        CFG_SYNC_SHIFT = 2'd1,
        CFG_PROP_GAIN  = 2'd2,
        CFG_INTEG_GAIN = 2'd3
    } cfg_idx_t;

    // status of the serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

    // one multiply-accumulate command
    typedef struct packed {
        logic valid;
        logic clear;     // start a new sum with this term
        logic neg;       // subtract the term
        logic shift_hi;  // term weighs 2^32
    } mac_op_t;

endpackage

FILE: sv/dcsp_rem_unit.sv
// Serial restoring remainder unit: one dividend bit per cycle.
// Depends on dcsp_pkg.
module dcsp_rem_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dcsp_pkg::MAG_W-1:0] dividend,
    input  logic [dcsp_pkg::CYC_W-1:0] divisor,
    output dcsp_pkg::rem_stat_t        stat,
    output logic [dcsp_pkg::CYC_W-1:0] rem
);
    import dcsp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0]     dividend_reg;
    logic [CYC_W-1:0]     divisor_reg;
    logic [CYC_W-1:0]     rem_reg;
    logic [CYC_W-1:0]     rem_next;
    logic [CYC_W+1:0]     trial;

    // shift in the next bit; keep the difference when it does not borrow
    always_comb
    begin
        trial = {1'b0, rem_reg, dividend_reg[MAG_W-1]} - {2'b00, divisor_reg};
        if (!trial[CYC_W+1])
        begin
            rem_next = trial[CYC_W-1:0];
        end
        else
        begin
            rem_next = {rem_reg[CYC_W-2:0], dividend_reg[MAG_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(MAG_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < divisor_reg)
        else $error("remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

endmodule

FILE: sv/dcsp_mac_unit.sv
// Shared 32x32 multiplier with a registered product, followed by a
// signed accumulator for the exact PI sum. Depends on dcsp_pkg.
module dcsp_mac_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dcsp_pkg::mac_op_t           op,
    input  logic [dcsp_pkg::MUL_W-1:0]  a,
    input  logic [dcsp_pkg::MUL_W-1:0]  b,
    output logic [dcsp_pkg::ACC_W-1:0]  acc
);
    import dcsp_pkg::*;

    mac_op_t          op_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] prod_ext;
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] acc_next;

    // subtract as add of the inverted term with carry in
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod_reg};
        term     = op_reg.shift_hi ? (prod_ext << GAIN_W) : prod_ext;
        base     = op_reg.clear ? '0 : acc_reg;
        acc_next = base + (term ^ {ACC_W{op_reg.neg}}) + ACC_W'(op_reg.neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg <= a * b;
        end
        if (op_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: sv/dc_clock_sync_pi_unit.sv
// Top level of the distributed-clock sync PI unit: sequencer, registers,
// integral and output saturation. Depends on dcsp_pkg, dcsp_rem_unit, dcsp_mac_unit.
//
//  channel | signals                          | direction | beat when
//  --------+----------------------------------+-----------+--------------------
//  in      | in_valid, in_stall, dc_time      | in        | in_valid & !in_stall
//  out     | out_valid, out_stall, offset_ns  | out       | out_valid & !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data      | in        | cfg_we
//
// The serial remainder (one bit of the 63-bit time difference per cycle) takes
// most of a beat; the rest is three passes through the shared 32x32 multiplier
// and the sequencer steps around them.
// in_stall is high from acceptance until the result is loaded into the output
// register; a result waiting on out_stall does not block the next beat.
// Reset restores the register defaults and clears the phase integral.
module dc_clock_sync_pi_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcsp_pkg::TIME_W-1:0]         dc_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dcsp_pkg::OUT_W-1:0]   offset_ns,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [dcsp_pkg::CFG_W-1:0]          cfg_data
);
    import dcsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_DIV,
        S_WRAP,
        S_INTEG,
        S_IMAG,
        S_MAC,
        S_DRAIN,
        S_NEG,
        S_FIN
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 step_reg;
    logic [CYC_W-1:0]           cycle_time_reg;
    logic [CYC_W-1:0]           sync_shift_reg;
    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic                       out_valid_reg;

    logic signed [DIFF_W-1:0]   diff_reg;
    logic [CYC_W-1:0]           cyc_eff_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [CYC_W-1:0]           dmag_reg;
    logic                       dneg_reg;
    logic [INTEG_W-1:0]         imag_reg;
    logic                       ineg_reg;
    logic [ACC_W-1:0]           mag_reg;
    logic [OUT_W-1:0]           offset_reg;

    logic                       in_beat;
    logic                       out_free;
    logic [MAG_W-1:0]           abs_diff;
    rem_stat_t                  rem_stat;
    logic [CYC_W-1:0]           rem_val;
    mac_op_t                    mac_op;
    logic [MUL_W-1:0]           mac_a;
    logic [MUL_W-1:0]           mac_b;
    logic [ACC_W-1:0]           acc;
    logic signed [INTEG_W:0]    isum;
    logic signed [INTEG_W-1:0]  integ_next;
    logic [Q_W-1:0]             quot;
    logic [OUT_W-1:0]           offset_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign offset_ns = offset_reg;

    assign abs_diff = diff_reg[DIFF_W-1] ? MAG_W'(-diff_reg) : diff_reg[MAG_W-1:0];

    dcsp_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_ABS),
        .dividend (abs_diff),
        .divisor  (cyc_eff_reg),
        .stat     (rem_stat),
        .rem      (rem_val)
    );

    // proportional term, then integral low and high halves
    always_comb
    begin
        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;
        if (state_reg == S_MAC)
        begin
            mac_op.valid = 1'b1;
            unique case (step_reg)
                2'd0:
                begin
                    mac_op.clear = 1'b1;
                    mac_op.neg   = dneg_reg;
                    mac_a        = MUL_W'(dmag_reg);
                    mac_b        = prop_gain_reg;
                end
                2'd1:
                begin
                    mac_op.neg = ineg_reg;
                    mac_a      = imag_reg[MUL_W-1:0];
                    mac_b      = integ_gain_reg;
                end
                default:
                begin
                    mac_op.neg      = ineg_reg;
                    mac_op.shift_hi = 1'b1;
                    mac_a           = MUL_W'(imag_reg >> MUL_W);
                    mac_b           = integ_gain_reg;
                end
            endcase
        end
    end

    dcsp_mac_unit u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    // saturating integral update
    always_comb
    begin
        isum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(delta_reg);
        if (isum[INTEG_W] != isum[INTEG_W-1])
        begin
            integ_next = isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_next = isum[INTEG_W-1:0];
        end
    end

    // truncate toward zero on the magnitude, then clamp to the output range
    always_comb
    begin
        quot = mag_reg[ACC_W-1:GAIN_W];
        if (dneg_reg)
        begin
            offset_next = (quot > OUT_NEG_MAG) ? OUT_MIN : OUT_W'(-quot);
        end
        else
        begin
            offset_next = (quot > OUT_POS_MAX) ? OUT_MAX : quot[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            cycle_time_reg <= CYCLE_TIME_RST;
            sync_shift_reg <= SYNC_SHIFT_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            integ_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CYCLE_TIME: cycle_time_reg <= cfg_data[CYC_W-1:0];
                    CFG_SYNC_SHIFT: sync_shift_reg <= cfg_data[CYC_W-1:0];
                    CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                endcase
            end

            priority if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= S_ABS;
                    end
                end
                S_ABS:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_stat.done)
                    begin
                        state_reg <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    state_reg <= S_INTEG;
                end
                S_INTEG:
                begin
                    integ_reg <= integ_next;
                    state_reg <= S_IMAG;
                end
                S_IMAG:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_NEG;
                end
                S_NEG:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            diff_reg    <= $signed({1'b0, dc_time}) -
                           $signed({{(DIFF_W-CYC_W){1'b0}}, sync_shift_reg});
            cyc_eff_reg <= (cycle_time_reg == '0) ? CYC_W'(1) : cycle_time_reg;
        end
        if (state_reg == S_WRAP)
        begin
            // negative differences never wrap; positive ones past half a cycle do
            if (diff_reg[DIFF_W-1])
            begin
                delta_reg <= -$signed({1'b0, rem_val});
                dmag_reg  <= rem_val;
                dneg_reg  <= 1'b1;
            end
            else if (rem_val > (cyc_eff_reg >> 1))
            begin
                delta_reg <= $signed({1'b0, rem_val}) - $signed({1'b0, cyc_eff_reg});
                dmag_reg  <= cyc_eff_reg - rem_val;
                dneg_reg  <= 1'b1;
            end
            else
            begin
                delta_reg <= $signed({1'b0, rem_val});
                dmag_reg  <= rem_val;
                dneg_reg  <= 1'b0;
            end
        end
        if (state_reg == S_IMAG)
        begin
            ineg_reg <= integ_reg[INTEG_W-1];
            imag_reg <= integ_reg[INTEG_W-1] ? INTEG_W'(-integ_reg) : INTEG_W'(integ_reg);
        end
        if (state_reg == S_NEG)
        begin
            // sign of the sum now travels in dneg_reg
            dneg_reg <= acc[ACC_W-1];
            mag_reg  <= acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
        end
        if (state_reg == S_FIN && out_free)
        begin
            offset_reg <= offset_next;
        end
    end

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_stat.busy || rem_stat.done))
        else $error("waiting on an idle remainder unit");

    a_err_below_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INTEG) |-> (dmag_reg < cyc_eff_reg))
        else $error("phase error magnitude not below cycle time");

    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside the final step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_ABS))
        else $error("accepted beat did not start the sequence");

endmodule

FILE: tb/dc_clock_sync_pi_unit_tb.sv
// Self-checking bench for dc_clock_sync_pi_unit: phase error, integral and PI
// correction are predicted per beat and compared with offset_ns.
// Depends on dcsp_pkg and the dc_clock_sync_pi_unit RTL.
module dc_clock_sync_pi_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcsp_pkg::*;

    localparam int  SETTLE     = 80;         // about one beat of block latency
    localparam int  CYCLE_MAX  = 2_000_000;
    localparam int  PHASE_LEN  = 106;
    localparam int  N_PHASES   = 8;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [TIME_W-1:0]        dc_time   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [OUT_W-1:0]  offset_ns;
    logic                     cfg_we    = 1'b0;
    logic [1:0]               cfg_index = CFG_CYCLE_TIME;
    logic [CFG_W-1:0]         cfg_data  = '0;

    // shadow copy of the block's registers and integral
    logic [CYC_W-1:0]         cyc_ns    = CYCLE_TIME_RST;
    logic [CYC_W-1:0]         shift_ns  = SYNC_SHIFT_RST;
    logic [GAIN_W-1:0]        p_gain    = PROP_GAIN_RST;
    logic [GAIN_W-1:0]        i_gain    = INTEG_GAIN_RST;
    longint                   phase_acc = 0;

    logic [TIME_W-1:0]        time_q[$];
    logic signed [OUT_W-1:0]  offset_q[$];
    int                       err_cnt   = 0;
    int                       burst_left = 1;
    int                       gap_left  = 0;
    int                       stall_mode = 0;
    int                       stall_len = 0;
    int                       cycles    = 0;

    dc_clock_sync_pi_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dc_time   (dc_time),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .offset_ns (offset_ns),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // phase error, saturating integral update, truncated PI correction
    function automatic logic signed [OUT_W-1:0] calc_offset(input logic [TIME_W-1:0] t);
        longint              cyc, diff, err, imax, imin;
        logic signed [127:0] e_w, i_w, pg_w, ig_w, acc, q, lim;
        logic                neg;
        cyc  = (cyc_ns == 0) ? 1 : longint'(cyc_ns);
        diff = longint'({1'b0, t}) - longint'(shift_ns);
        err  = diff % cyc;
        if (err > cyc / 2)
            err -= cyc;
        imax = (longint'(1) << (INTEG_W - 1)) - 1;
        imin = -imax - 1;
        if (err > 0 && phase_acc > imax - err)
            phase_acc = imax;
        else if (err < 0 && phase_acc < imin - err)
            phase_acc = imin;
        else
            phase_acc += err;
        e_w  = err;
        i_w  = phase_acc;
        pg_w = {96'd0, p_gain};
        ig_w = {96'd0, i_gain};
        acc  = e_w * pg_w + i_w * ig_w;
        neg  = acc[127];
        q    = (neg ? -acc : acc) >> GAIN_W;
        lim  = neg ? (128'sd1 <<< (OUT_W - 1)) : ((128'sd1 <<< (OUT_W - 1)) - 1);
        if (q > lim)
            q = lim;
        return OUT_W'(neg ? -q : q);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        else if (r < 7)
            return $urandom_range(1, 12);
        return $urandom_range(13, 150);
    endfunction

    // mostly times near the target phase of some bus cycle, some noise
    function automatic logic [TIME_W-1:0] pick_time(input int bias);
        longint      cyc, span, jit, t;
        logic [63:0] raw;
        cyc = (cyc_ns == 0) ? 1 : longint'(cyc_ns);
        if ($urandom_range(0, 99) < 75)
        begin
            span = cyc / 2;
            if ($urandom_range(0, 3) == 0 && span > 2000)
                span = 2000;
            if (bias == 0)
                jit = longint'($urandom_range(0, 32'(2 * span))) - span;
            else
                jit = bias * longint'($urandom_range(0, 32'(span)));
            t = longint'(shift_ns) + longint'($urandom_range(0, 32'hFFFF_FFFF)) * cyc + jit;
            if (t < 0)
                t = -t;
            return TIME_W'(t);
        end
        case ($urandom_range(0, 2))
            0: raw = {$urandom, $urandom};
            1: raw = 64'($urandom_range(0, 32'(shift_ns)));
            default: raw = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000000));
        endcase
        return raw[TIME_W-1:0];
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CYCLE_TIME: cyc_ns   = val[CYC_W-1:0];
            CFG_SYNC_SHIFT: shift_ns = val[CYC_W-1:0];
            CFG_PROP_GAIN:  p_gain   = val;
            CFG_INTEG_GAIN: i_gain   = val;
        endcase
    endtask

    // sender holds off until every beat has come back
    task automatic drain();
        while (time_q.size() != 0 || in_valid || offset_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_phase(input int sel);
        logic [CFG_W-1:0] c, s, p, g;
        // raw 32-bit values: the block keeps only the low CYC_W bits of cycle time and shift
        c = $urandom;
        s = $urandom;
        p = $urandom;
        g = $urandom;
        case (sel)
            0:
            begin
                c = {2'b00, {CYC_W{1'b1}}};
                s = $urandom_range(0, 1000);
                p = '1;
                g = '1;
            end
            1:
            begin
                c = $urandom_range(1, 20);
                s = '0;
            end
            2: c = '0;
            3:
            begin
                c = $urandom_range(1000000, 50000000);
                s = $urandom_range(0, c);
                p = $urandom_range(0, 100000000);
                g = $urandom_range(0, 1000000);
            end
            4:
            begin
                p = '0;
                g = '0;
            end
            5:
            begin
                s = {2'b00, {CYC_W{1'b1}}};
                c = $urandom_range(1, 1000000);
            end
            default: ;
        endcase
        write_reg(CFG_CYCLE_TIME, c);
        write_reg(CFG_SYNC_SHIFT, s);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, g);
    endtask

    // input driver: bursts of beats separated by random gaps
    always @(posedge clk)
    begin : feed
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                offset_q.push_back(calc_offset(dc_time));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (time_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    dc_time  <= time_q.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = pick_gap();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall: segments of no stall, coin flips, heavy stall, solid stall
    always @(posedge clk)
    begin : stall_gen
        if (stall_len == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_len  = (stall_mode == 3) ? $urandom_range(20, 150) : $urandom_range(50, 600);
        end
        else
        begin
            stall_len--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : check_out
        logic signed [OUT_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (offset_q.size() == 0)
            begin
                err_cnt++;
                $error("offset_ns: got %0d with no beat pending", offset_ns);
            end
            else
            begin
                want = offset_q.pop_front();
                if (offset_ns !== want)
                begin
                    err_cnt++;
                    $error("offset_ns: expected %0d, actual %0d", want, offset_ns);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles >= CYCLE_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int bias;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: below shift, on target, half cycle, just past half
        time_q.push_back(63'd0);
        time_q.push_back(63'd499_999);
        time_q.push_back(63'd500_000);
        time_q.push_back(63'd25_500_000);
        time_q.push_back(63'd25_500_001);
        time_q.push_back(63'd50_499_999);
        time_q.push_back({TIME_W{1'b1}});
        drain();

        // zero cycle time behaves as a cycle of one
        write_reg(CFG_CYCLE_TIME, '0);
        time_q.push_back({TIME_W{1'b1}});
        time_q.push_back(63'd0);
        drain();
        write_reg(CFG_CYCLE_TIME, 32'd1);
        write_reg(CFG_SYNC_SHIFT, 32'h3FFF_FFFF);
        time_q.push_back(63'd12345);
        drain();

        // largest negative error repeated until the output clips low
        write_reg(CFG_CYCLE_TIME, 32'h3FFF_FFFF);
        write_reg(CFG_SYNC_SHIFT, 32'hFFFF_FFFE);
        write_reg(CFG_PROP_GAIN, '1);
        write_reg(CFG_INTEG_GAIN, '1);
        repeat (10) time_q.push_back(63'd0);
        drain();

        // floor of an odd half cycle, then zero gains
        write_reg(CFG_SYNC_SHIFT, '0);
        time_q.push_back(63'd536_870_911);
        time_q.push_back(63'd536_870_912);
        drain();
        write_reg(CFG_PROP_GAIN, '0);
        write_reg(CFG_INTEG_GAIN, '0);
        time_q.push_back(63'd1_000);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            program_phase(ph);
            bias = (ph == 0) ? 1 : $urandom_range(0, 2) - 1;
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                time_q.push_back(pick_time(bias));
                if (ph == 3 && k == PHASE_LEN / 2)
                    drain();
            end
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
